[rtl/kpdt_pkg.sv]
// ----------------------------------------------------------------------------
// kpdt_pkg
// Shared constants and types of the pulse distance keyboard transmitter.
// ----------------------------------------------------------------------------
package kpdt_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  localparam int KEY_BITS  = 64;
  localparam int KEY_W     = $clog2(KEY_BITS);
  localparam int CODE_W    = 6;
  localparam int DATA_BITS = CODE_W + 1;   // inverted shift plus code bits
  localparam int DI_W      = $clog2(DATA_BITS);

  localparam logic [3:0] GAP_ONE  = 4'd7;
  localparam logic [3:0] GAP_ZERO = 4'd5;
  localparam logic [3:0] GAP_TAIL = 4'd14;

  // request types
  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic              load;
    logic              step;
    logic [CODE_W-1:0] code;
    logic              shift;
  } kpdt_frm_cmd_t;

  typedef struct packed {
    logic busy;
    logic level;
  } kpdt_frm_st_t;

endpackage

[rtl/kpdt_ram.sv]
// ----------------------------------------------------------------------------
// kpdt_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kpdt_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 6
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/kpdt_frame.sv]
// ----------------------------------------------------------------------------
// kpdt_frame
// Frame sequencer: walks start pulse, seven data bits and tail, one level
// per step.
// ----------------------------------------------------------------------------
module kpdt_frame
  import kpdt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  kpdt_frm_cmd_t cmd,
  output kpdt_frm_st_t  st
);

  typedef enum logic [2:0] {
    F_START, F_GAP, F_PULSE, F_TGAP, F_TPULSE, F_LOW, F_DONE
  } frm_state_t;

  frm_state_t           state_r, state_nxt;
  logic [DATA_BITS-1:0] data_r, data_nxt;
  logic [DI_W-1:0]      bi_r, bi_nxt;
  logic [3:0]           gcnt_r, gcnt_nxt;
  logic [DI_W-1:0]      nb;

  assign nb = bi_r + DI_W'(1);

  always_comb begin
    state_nxt = state_r;
    data_nxt  = data_r;
    bi_nxt    = bi_r;
    gcnt_nxt  = gcnt_r;
    if (cmd.load) begin
      data_nxt  = {cmd.code, ~cmd.shift};
      bi_nxt    = '0;
      state_nxt = F_START;
    end else if (cmd.step) begin
      case (state_r)
        F_START: begin
          gcnt_nxt  = data_r[0] ? GAP_ONE : GAP_ZERO;
          bi_nxt    = '0;
          state_nxt = F_GAP;
        end
        F_GAP: begin
          gcnt_nxt = gcnt_r - 4'd1;
          if (gcnt_r == 4'd1) state_nxt = F_PULSE;
        end
        F_PULSE: begin
          if (bi_r == DI_W'(DATA_BITS - 1)) begin
            gcnt_nxt  = GAP_TAIL;
            state_nxt = F_TGAP;
          end else begin
            bi_nxt    = nb;
            gcnt_nxt  = data_r[nb] ? GAP_ONE : GAP_ZERO;
            state_nxt = F_GAP;
          end
        end
        F_TGAP: begin
          gcnt_nxt = gcnt_r - 4'd1;
          if (gcnt_r == 4'd1) state_nxt = F_TPULSE;
        end
        F_TPULSE: state_nxt = F_LOW;
        F_LOW:    state_nxt = F_DONE;
        default:  state_nxt = F_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_DONE;
    end else begin
      state_r <= state_nxt;
    end
    data_r <= data_nxt;
    bi_r   <= bi_nxt;
    gcnt_r <= gcnt_nxt;
  end

  always_comb begin
    st.busy = (state_r != F_DONE);
    case (state_r)
      F_START, F_PULSE, F_TPULSE: st.level = 1'b1;
      default:                    st.level = 1'b0;
    endcase
  end

endmodule

[rtl/keyboard_pulse_distance_transmitter_unit.sv]
// ----------------------------------------------------------------------------
// keyboard_pulse_distance_transmitter_unit
// Key matrix scanner with a code queue in RAM and a pulse distance framer.
// ----------------------------------------------------------------------------
// Scan request: one key bit per cycle walked by the key counter; when a frame
//   starts, a queue RAM read state and then a load state follow.
// Tick request: a busy framer's level sits in the output register next cycle.
// A new request is taken while a result waits, when the output frees up.
// Reset clears pointers, count, previous matrix and framer; queue RAM is
//   not cleared, only written entries are ever read.
module keyboard_pulse_distance_transmitter_unit
  import kpdt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  logic [KEY_BITS-1:0] in_key_matrix,
  input  logic                in_shift_line,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_pulse_level
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_READ, S_LOAD} state_t;

  state_t              state_r, state_nxt;
  logic [KEY_BITS-1:0] prev_r, prev_nxt;
  logic [KEY_BITS-1:0] fresh_r, fresh_nxt;
  logic                shift_r, shift_nxt;
  logic [KEY_W-1:0]    k_r, k_nxt;
  logic [QA_W-1:0]     head_r, head_nxt;
  logic [QA_W-1:0]     tail_r, tail_nxt;
  logic [QC_W-1:0]     count_r, count_nxt;
  logic                sending_r, sending_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_level_r, out_level_nxt;

  logic              acc;
  logic              we;
  logic              re;
  logic [CODE_W-1:0] rdata;
  kpdt_frm_cmd_t     frm_cmd;
  kpdt_frm_st_t      frm_st;

  assign in_ready        = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign acc             = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_pulse_level = out_level_r;

  // pointer wrap that holds for any depth
  function automatic logic [QA_W-1:0] ptr_inc(input logic [QA_W-1:0] p);
    if (p == QA_W'(QUEUE_DEPTH - 1)) return '0;
    return p + QA_W'(1);
  endfunction

  always_comb begin
    state_nxt     = state_r;
    prev_nxt      = prev_r;
    fresh_nxt     = fresh_r;
    shift_nxt     = shift_r;
    k_nxt         = k_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    sending_nxt   = sending_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_level_nxt = out_level_r;
    we            = 1'b0;
    re            = 1'b0;
    frm_cmd       = '0;
    frm_cmd.code  = rdata;
    frm_cmd.shift = shift_r;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_req_type == REQ_SCAN) begin
            fresh_nxt = in_key_matrix & ~prev_r;
            prev_nxt  = in_key_matrix;
            shift_nxt = in_shift_line;
            k_nxt     = '0;
            state_nxt = S_SCAN;
          end else if (frm_st.busy) begin
            // tick with levels left: emit one
            out_valid_nxt = 1'b1;
            out_level_nxt = frm_st.level;
            frm_cmd.step  = 1'b1;
          end else begin
            sending_nxt = 1'b0;
          end
        end
      end
      S_SCAN: begin
        // new key goes in unless the queue is full
        if (fresh_r[k_r] && (count_r < QC_W'(QUEUE_DEPTH))) begin
          we        = 1'b1;
          tail_nxt  = ptr_inc(tail_r);
          count_nxt = count_r + QC_W'(1);
        end
        k_nxt = k_r + KEY_W'(1);
        if (k_r == KEY_W'(KEY_BITS - 1)) begin
          state_nxt = (!sending_r && (count_nxt != '0)) ? S_READ : S_IDLE;
        end
      end
      S_READ: begin
        re        = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        frm_cmd.load = 1'b1;
        head_nxt     = ptr_inc(head_r);
        count_nxt    = count_r - QC_W'(1);
        sending_nxt  = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      sending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      sending_r   <= sending_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fresh_r     <= fresh_nxt;
    shift_r     <= shift_nxt;
    k_r         <= k_nxt;
    out_level_r <= out_level_nxt;
  end

  // code queue storage
  kpdt_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (CODE_W)
  ) u_queue (
    .clk   (clk),
    .we    (we),
    .waddr (tail_r),
    .wdata (CODE_W'(k_r)),
    .re    (re),
    .raddr (head_r),
    .rdata (rdata)
  );

  kpdt_frame u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (frm_cmd),
    .st    (frm_st)
  );

  // queue never overfills
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QC_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // a frame only starts from a non-empty queue while not sending
  a_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> (count_r != '0) && !sending_r)
    else $error("frame load without code or while sending");

  // framer busy implies the sending flag
  a_busy_sending: assert property (@(posedge clk) disable iff (!rst_n)
    frm_st.busy |-> sending_r)
    else $error("framer busy while not sending");

  // an accepted tick with levels left yields a result
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_req_type == REQ_TICK) && frm_st.busy) |=> out_valid_r)
    else $error("tick lost its level");

  // an accepted scan starts the key walk from the first key
  a_scan_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_req_type == REQ_SCAN)) |=> (state_r == S_SCAN) && (k_r == '0))
    else $error("scan did not start key walk");

endmodule
